/* rtl/rxdfr_pkg.sv */
// Shared constants, codes and types for the receive deframer with burst tracking.
// No dependencies; rx_deframer_burst_tracker_top and the testbench import this package.

package rxdfr_pkg;

	localparam int CHANNELS    = 32;
	localparam int MAX_PAYLOAD = 13;
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef logic [7:0]  octet_t;
	typedef logic [3:0]  len_t;
	typedef logic [15:0] bcount_t;

	localparam octet_t  SYNC_RESET  = 8'd164;
	localparam octet_t  BURST_RESET = 8'd80;
	localparam bcount_t BURST_STEP  = 16'd8;
	localparam bcount_t BCOUNT_MAX  = 16'hffff;

	// Configuration register indexes
	localparam logic CFG_SYNC_BYTE = 1'b0;
	localparam logic CFG_BURST_ID  = 1'b1;

	// Result status
	localparam logic ST_PAYLOAD = 1'b0;
	localparam logic ST_BAD_SUM = 1'b1;

	// Burst tracking outcome
	localparam logic [2:0] BST_NONE     = 3'd0;
	localparam logic [2:0] BST_START    = 3'd1;
	localparam logic [2:0] BST_CONTINUE = 3'd2;
	localparam logic [2:0] BST_DROP     = 3'd3;
	localparam logic [2:0] BST_RESTART  = 3'd4;
	localparam logic [2:0] BST_COMPLETE = 3'd5;

endpackage

/* rtl/rxdfr_if.sv */
// Handshake channels of the receive deframer: byte input, result output and
// configuration writes. Standalone; no package needed.

interface rxdfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rxdfr_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [7:0]  msg_id;
	logic [7:0]  data_byte;
	logic [3:0]  byte_index;
	logic [3:0]  payload_len;
	logic        last;
	logic [2:0]  burst_status;
	logic [4:0]  burst_channel;
	logic [15:0] burst_bytes;
	modport source (output valid, output status, output msg_id, output data_byte,
		output byte_index, output payload_len, output last, output burst_status,
		output burst_channel, output burst_bytes, input ready);
	modport sink (input valid, input status, input msg_id, input data_byte,
		input byte_index, input payload_len, input last, input burst_status,
		input burst_channel, input burst_bytes, output ready);
endinterface

interface rxdfr_cfg_if;
	logic       valid;
	logic       ready;
	logic       reg_index;
	logic [7:0] wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/rx_deframer_burst_tracker_top.sv */
// Receive deframer: sync/length/id/payload/checksum parser, per-channel burst
// tracker and result drain buffer. Depends on rxdfr_pkg and rxdfr_if.sv.
// Latency: the first result of a frame is presented the cycle after its checksum
//   byte is accepted; the frame's results then leave one per cycle while res.ready is high.
// Throughput: one received byte per cycle. A checksum byte waits only while the
//   previous frame's results are still in the drain buffer.
// Reset: parser hunts for sync, burst table cleared, registers at defaults.

module rx_deframer_burst_tracker_top import rxdfr_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rxdfr_cfg_if.sink   cfg,
	rxdfr_byte_if.sink  rx,
	rxdfr_res_if.source res
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_ID   = 3'd2;
	localparam logic [2:0] PH_PAY  = 3'd3;
	localparam logic [2:0] PH_CHK  = 3'd4;

	// configuration
	octet_t sync_q, burst_id_q;

	// parser state
	logic [2:0] phase_q;
	len_t       flen_q;
	octet_t     fid_q;
	octet_t     xor_q;
	len_t       seen_q;
	octet_t     store_q [MAX_PAYLOAD];

	// burst table
	logic       act_q  [CHANNELS];
	logic [1:0] lseq_q [CHANNELS];
	bcount_t    cnt_q  [CHANNELS];

	// drain buffer
	logic       busy_q;
	len_t       idx_q;
	len_t       dlen_q;
	octet_t     did_q;
	logic       dstat_q;
	logic [2:0] dbst_q;
	logic [4:0] dbch_q;
	bcount_t    dbby_q;
	octet_t     dbuf_q [MAX_PAYLOAD];

	logic    rx_fire, res_fire, cfg_fire, is_chk;
	octet_t  b;
	logic    sum_ok, is_burst;

	// burst tracking
	octet_t          head;
	logic [1:0]      seq;
	logic            fin, ch_ok;
	logic [CH_W-1:0] ch;
	logic            cur_act;
	logic [1:0]      cur_ls;
	bcount_t         cur_cnt;
	logic [16:0]     sum17;
	bcount_t         sat_cnt;
	logic [2:0]      b_st;
	bcount_t         b_bytes;
	logic            b_wr, nx_act;
	logic [1:0]      nx_ls;
	bcount_t         nx_cnt;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	assign is_chk   = (phase_q == PH_CHK);
	assign rx.ready = !(is_chk && busy_q);
	assign rx_fire  = rx.valid & rx.ready;
	assign b        = rx.rx_byte;
	assign sum_ok   = ((xor_q ^ b) == 8'h00);
	assign is_burst = sum_ok && (fid_q == burst_id_q);

	assign head    = store_q[0];
	assign seq     = head[6:5];
	assign fin     = head[7];
	assign ch      = head[CH_W-1:0];
	assign ch_ok   = ({1'b0, head[4:0]} < 6'(CHANNELS));
	assign cur_act = act_q[ch];
	assign cur_ls  = lseq_q[ch];
	assign cur_cnt = cnt_q[ch];
	assign sum17   = {1'b0, cur_cnt} + {1'b0, BURST_STEP};
	assign sat_cnt = sum17[16] ? BCOUNT_MAX : sum17[15:0];

	always_comb begin
		b_st    = BST_DROP;
		b_bytes = '0;
		b_wr    = 1'b0;
		nx_act  = cur_act;
		nx_ls   = cur_ls;
		nx_cnt  = cur_cnt;
		if (ch_ok) begin
			if (!cur_act) begin
				if (seq == 2'd0) begin
					b_wr   = 1'b1;
					nx_act = 1'b1;
					nx_cnt = BURST_STEP;
					nx_ls  = 2'd0;
					b_st   = BST_START;
				end
			end else if ({1'b0, cur_ls} + 3'd1 != {1'b0, seq}) begin
				// out of sequence: clear, then restart only on a first segment
				b_wr   = 1'b1;
				nx_act = 1'b0;
				nx_cnt = '0;
				if (seq == 2'd0) begin
					nx_act = 1'b1;
					nx_cnt = BURST_STEP;
					nx_ls  = 2'd0;
					b_st   = BST_RESTART;
				end
			end else begin
				b_wr   = 1'b1;
				nx_cnt = sat_cnt;
				nx_ls  = (seq == 2'd3) ? 2'd0 : seq;
				b_st   = BST_CONTINUE;
			end
			if (b_st != BST_DROP) begin
				b_bytes = nx_cnt;
				if (fin) begin
					nx_act = 1'b0;
					nx_cnt = '0;
					nx_ls  = 2'd0;
					b_st   = BST_COMPLETE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q     <= SYNC_RESET;
			burst_id_q <= BURST_RESET;
		end else if (cfg_fire) begin
			case (cfg.reg_index)
				CFG_SYNC_BYTE: sync_q     <= cfg.wdata;
				CFG_BURST_ID:  burst_id_q <= cfg.wdata;
				default:       sync_q     <= sync_q;
			endcase
		end
	end

	// parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			flen_q  <= '0;
			fid_q   <= '0;
			xor_q   <= '0;
			seen_q  <= '0;
		end else if (rx_fire) begin
			case (phase_q)
				PH_LEN: begin
					if (b >= 8'd1 && b <= 8'(MAX_PAYLOAD)) begin
						flen_q  <= b[3:0];
						xor_q   <= xor_q ^ b;
						phase_q <= PH_ID;
					end else if (b == sync_q) begin
						xor_q   <= b;
						phase_q <= PH_LEN;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_ID: begin
					fid_q   <= b;
					xor_q   <= xor_q ^ b;
					seen_q  <= '0;
					phase_q <= PH_PAY;
				end
				PH_PAY: begin
					xor_q  <= xor_q ^ b;
					seen_q <= seen_q + 4'd1;
					if (seen_q + 4'd1 >= flen_q)
						phase_q <= PH_CHK;
				end
				PH_CHK: begin
					xor_q   <= xor_q ^ b;
					phase_q <= PH_HUNT;
				end
				default: begin
					if (b == sync_q) begin
						xor_q   <= b;
						phase_q <= PH_LEN;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_PAY && seen_q < 4'(MAX_PAYLOAD))
			store_q[seen_q] <= b;
	end

	// burst table: at most one channel read and written per burst frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				act_q[i]  <= 1'b0;
				lseq_q[i] <= 2'd0;
				cnt_q[i]  <= '0;
			end
		end else if (rx_fire && is_chk && is_burst && b_wr) begin
			act_q[ch]  <= nx_act;
			lseq_q[ch] <= nx_ls;
			cnt_q[ch]  <= nx_cnt;
		end
	end

	// drain buffer: load on the checksum byte, release one result per request
	assign res_fire = res.valid & res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (rx_fire && is_chk) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (res_fire) begin
			if (res.last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && is_chk) begin
			dlen_q  <= flen_q;
			did_q   <= fid_q;
			dstat_q <= sum_ok ? ST_PAYLOAD : ST_BAD_SUM;
			dbst_q  <= is_burst ? b_st : BST_NONE;
			dbch_q  <= is_burst ? head[4:0] : 5'd0;
			dbby_q  <= is_burst ? b_bytes : 16'd0;
			dbuf_q  <= store_q;
		end
	end

	assign res.valid         = busy_q;
	assign res.status        = dstat_q;
	assign res.msg_id        = did_q;
	assign res.data_byte     = (dstat_q == ST_BAD_SUM) ? 8'h00 : dbuf_q[idx_q];
	assign res.byte_index    = idx_q;
	assign res.payload_len   = dlen_q;
	assign res.last          = (dstat_q == ST_BAD_SUM) || (idx_q + 4'd1 == dlen_q);
	assign res.burst_status  = dbst_q;
	assign res.burst_channel = dbch_q;
	assign res.burst_bytes   = dbby_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < dlen_q))
		else $error("drain index beyond payload length");

	a_stall_only_on_chk: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (busy_q && phase_q == PH_CHK))
		else $error("input stalled outside a pending checksum");

	a_pay_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAY) |-> (seen_q < flen_q))
		else $error("payload count overran frame length");

	a_bad_sum_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && dstat_q == ST_BAD_SUM) |-> (dbst_q == BST_NONE && idx_q == 4'd0))
		else $error("rejected frame carries burst result");

	a_drop_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && dbst_q == BST_DROP) |-> (dbby_q == 16'd0))
		else $error("dropped burst reports bytes");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rx_deframer_burst_tracker_top: frames are built and sent byte by
// byte, an in-bench deframer and burst tracker predicts every result. Needs rxdfr_pkg, rxdfr_if.

module tb;
	import rxdfr_pkg::*;

	localparam int LIMIT = 400000;

	typedef enum logic [2:0] {P_HUNT, P_LEN, P_ID, P_PAY, P_CHK} parse_phase_t;

	typedef struct packed {
		logic       status;
		octet_t     msg_id;
		octet_t     data_byte;
		len_t       byte_index;
		len_t       payload_len;
		logic       last;
		logic [2:0] burst_status;
		logic [4:0] burst_channel;
		bcount_t    burst_bytes;
	} frame_result_t;

	logic clk;
	logic arst_n;

	rxdfr_cfg_if  cfg ();
	rxdfr_byte_if rx ();
	rxdfr_res_if  res ();

	rx_deframer_burst_tracker_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.res    (res)
	);

	// predicted deframer state
	parse_phase_t ph;
	len_t         flen;
	octet_t       fid;
	octet_t       fxor;
	len_t         nseen;
	octet_t       pstore [MAX_PAYLOAD];
	logic         bactive [CHANNELS];
	logic [1:0]   blast_seq [CHANNELS];
	bcount_t      bcount [CHANNELS];
	octet_t       pr_sync;
	octet_t       pr_burst;

	frame_result_t frame_results_due [$];

	// stimulus side
	octet_t     frame_pl [MAX_PAYLOAD];
	octet_t     frame_sync;
	octet_t     frame_burst;
	logic [1:0] next_seq [CHANNELS];
	int         items_sent;
	int         errors;
	int         cycles;
	int         hold_cycles;
	bit         src_idle;
	bit         sink_idle;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** rx_deframer_burst_tracker_top: FAILED **");
			$finish;
		end
	end

	task automatic reset_model();
		ph = P_HUNT;
		flen = '0;
		fid = '0;
		fxor = '0;
		nseen = '0;
		pr_sync = SYNC_RESET;
		pr_burst = BURST_RESET;
		for (int i = 0; i < MAX_PAYLOAD; i++) pstore[i] = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			bactive[i] = 1'b0;
			blast_seq[i] = '0;
			bcount[i] = '0;
		end
	endtask

	task automatic hunt_sync(input octet_t b);
		if (b == pr_sync) begin
			fxor = b;
			ph = P_LEN;
		end else begin
			ph = P_HUNT;
		end
	endtask

	task automatic advance_burst(input octet_t head, output logic [2:0] st,
			output logic [4:0] ch, output bcount_t cnt);
		logic [1:0] seq;
		logic       fin;
		seq = head[6:5];
		fin = head[7];
		ch = head[4:0];
		cnt = '0;
		st = BST_DROP;
		if (int'(ch) >= CHANNELS) return;
		if (!bactive[ch]) begin
			if (seq != 2'd0) return;
			bactive[ch] = 1'b1;
			bcount[ch] = BURST_STEP;
			blast_seq[ch] = 2'd0;
			st = BST_START;
		end else if (int'(blast_seq[ch]) + 1 != int'(seq)) begin
			// out of order: clear, and only a fresh seq 0 opens it again
			bactive[ch] = 1'b0;
			bcount[ch] = '0;
			if (seq != 2'd0) return;
			bactive[ch] = 1'b1;
			bcount[ch] = BURST_STEP;
			blast_seq[ch] = 2'd0;
			st = BST_RESTART;
		end else begin
			bcount[ch] = (32'(bcount[ch]) + 32'(BURST_STEP) > 32'(BCOUNT_MAX)) ?
				BCOUNT_MAX : bcount[ch] + BURST_STEP;
			blast_seq[ch] = (seq == 2'd3) ? 2'd0 : seq;
			st = BST_CONTINUE;
		end
		cnt = bcount[ch];
		if (fin) begin
			bactive[ch] = 1'b0;
			bcount[ch] = '0;
			blast_seq[ch] = 2'd0;
			st = BST_COMPLETE;
		end
	endtask

	task automatic deframe_byte(input octet_t b);
		frame_result_t r;
		logic [2:0]    bst;
		logic [4:0]    bch;
		bcount_t       bcnt;
		case (ph)
			P_LEN: begin
				if (b >= 8'd1 && b <= MAX_PAYLOAD) begin
					flen = len_t'(b);
					fxor ^= b;
					ph = P_ID;
				end else begin
					hunt_sync(b);
				end
			end
			P_ID: begin
				fid = b;
				fxor ^= b;
				nseen = '0;
				ph = P_PAY;
			end
			P_PAY: begin
				pstore[nseen] = b;
				fxor ^= b;
				nseen = nseen + 4'd1;
				if (nseen >= flen) ph = P_CHK;
			end
			P_CHK: begin
				fxor ^= b;
				ph = P_HUNT;
				r = '0;
				r.msg_id = fid;
				r.payload_len = flen;
				if (fxor != 8'd0) begin
					r.status = ST_BAD_SUM;
					r.last = 1'b1;
					frame_results_due.push_back(r);
				end else begin
					bst = BST_NONE;
					bch = '0;
					bcnt = '0;
					if (fid == pr_burst) advance_burst(pstore[0], bst, bch, bcnt);
					r.status = ST_PAYLOAD;
					r.burst_status = bst;
					r.burst_channel = bch;
					r.burst_bytes = bcnt;
					for (int k = 0; k < int'(flen); k++) begin
						r.data_byte = pstore[k];
						r.byte_index = len_t'(k);
						r.last = (k + 1 == int'(flen));
						frame_results_due.push_back(r);
					end
				end
			end
			default: hunt_sync(b);
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// score results first, then fold in this edge's config write and input byte
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (frame_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got msg_id %0d data %0d",
						$time, res.msg_id, res.data_byte);
					errors++;
				end else begin
					want = frame_results_due.pop_front();
					check_field("status", 16'(want.status), 16'(res.status));
					check_field("msg_id", 16'(want.msg_id), 16'(res.msg_id));
					check_field("data_byte", 16'(want.data_byte), 16'(res.data_byte));
					check_field("byte_index", 16'(want.byte_index), 16'(res.byte_index));
					check_field("payload_len", 16'(want.payload_len),
						16'(res.payload_len));
					check_field("last", 16'(want.last), 16'(res.last));
					check_field("burst_status", 16'(want.burst_status),
						16'(res.burst_status));
					check_field("burst_channel", 16'(want.burst_channel),
						16'(res.burst_channel));
					check_field("burst_bytes", want.burst_bytes, res.burst_bytes);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.reg_index == CFG_SYNC_BYTE) pr_sync = cfg.wdata;
				else pr_burst = cfg.wdata;
			end
			if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
		end
	end

	// result receiver: random stalls per request, plus an occasional long hold-off
	initial begin
		int gap;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				res.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = sink_idle ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid && hold_cycles == 0);
		end
	end

	task automatic send_byte(input octet_t b);
		int gap;
		gap = src_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
	endtask

	task automatic send_frame(input octet_t id, input int len, input bit bad_sum);
		octet_t sum;
		sum = frame_sync ^ octet_t'(len) ^ id;
		send_byte(frame_sync);
		send_byte(octet_t'(len));
		send_byte(id);
		for (int k = 0; k < len; k++) begin
			send_byte(frame_pl[k]);
			sum ^= frame_pl[k];
		end
		if (bad_sum) sum ^= octet_t'($urandom_range(1, 255));
		send_byte(sum);
		items_sent += len + 4;
	endtask

	task automatic send_burst(input int ch, input int seq, input bit fin, input int len,
			input bit bad_sum);
		for (int k = 0; k < MAX_PAYLOAD; k++) frame_pl[k] = octet_t'($urandom);
		frame_pl[0] = {fin, 2'(seq), 5'(ch)};
		send_frame(frame_burst, len, bad_sum);
	endtask

	// hold input, wait out every pending result and the parser's tail
	task automatic drain_results();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input octet_t val);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == CFG_SYNC_BYTE) frame_sync = val;
		else frame_burst = val;
	endtask

	task automatic test_plain_frames();
		for (int k = 0; k < MAX_PAYLOAD; k++) frame_pl[k] = 8'h00;
		send_frame(8'h00, 1, 1'b0);
		for (int k = 0; k < MAX_PAYLOAD; k++) frame_pl[k] = 8'hff;
		send_frame(8'hff, MAX_PAYLOAD, 1'b0);
		send_frame(8'h3c, MAX_PAYLOAD, 1'b1);
		// a burst-looking head under a non-burst id stays untracked
		frame_pl[0] = 8'h00;
		send_frame(frame_burst + 8'd1, 3, 1'b0);
		for (int k = 0; k < MAX_PAYLOAD; k++) frame_pl[k] = octet_t'($urandom);
		send_frame(octet_t'($urandom), 7, 1'b0);
	endtask

	task automatic test_length_errors();
		send_byte(8'h00);
		send_byte(8'h5a);
		send_byte(frame_sync);
		send_byte(8'd0);
		send_byte(frame_sync);
		send_byte(8'd14);
		send_byte(frame_sync);
		send_byte(8'hff);
		// length byte equal to sync opens a new frame right there
		send_byte(frame_sync);
		for (int k = 0; k < MAX_PAYLOAD; k++) frame_pl[k] = octet_t'($urandom);
		send_frame(8'h21, 2, 1'b0);
	endtask

	task automatic test_burst_sequences();
		send_burst(3, 0, 1'b0, 2, 1'b0);
		send_burst(3, 1, 1'b0, 1, 1'b0);
		send_burst(3, 2, 1'b0, 3, 1'b0);
		send_burst(3, 3, 1'b0, 1, 1'b0);
		send_burst(3, 1, 1'b0, 1, 1'b0);
		send_burst(3, 2, 1'b1, 2, 1'b0);
		send_burst(7, 2, 1'b0, 1, 1'b0);
		send_burst(9, 0, 1'b0, 1, 1'b0);
		send_burst(9, 0, 1'b0, 1, 1'b0);
		send_burst(9, 3, 1'b0, 1, 1'b0);
		send_burst(9, 1, 1'b0, 1, 1'b0);
		send_burst(12, 0, 1'b1, 1, 1'b0);
		send_burst(20, 0, 1'b0, 4, 1'b1);
		send_burst(20, 1, 1'b0, 1, 1'b0);
		send_burst(0, 0, 1'b0, MAX_PAYLOAD, 1'b0);
		send_burst(31, 0, 1'b1, 1, 1'b0);
	endtask

	task automatic test_backpressure();
		drain_results();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		hold_cycles = 400;
		for (int f = 0; f < 3; f++) send_burst(5, f % 4, 1'b0, MAX_PAYLOAD, 1'b0);
		drain_results();
	endtask

	task automatic test_register_settings();
		src_idle = 1'b1;
		sink_idle = 1'b1;
		cfg_write(CFG_SYNC_BYTE, 8'h00);
		cfg_write(CFG_BURST_ID, 8'h00);
		send_burst(2, 0, 1'b0, 1, 1'b0);
		send_byte(8'h00);
		send_burst(2, 1, 1'b0, 3, 1'b0);
		cfg_write(CFG_SYNC_BYTE, 8'hff);
		cfg_write(CFG_BURST_ID, 8'hff);
		send_byte(8'h00);
		send_burst(2, 2, 1'b1, 4, 1'b0);
		send_frame(8'h50, 5, 1'b0);
		// sync inside the legal length range
		cfg_write(CFG_SYNC_BYTE, 8'd9);
		send_frame(8'h33, 9, 1'b0);
		send_burst(4, 0, 1'b0, 2, 1'b0);
		cfg_write(CFG_SYNC_BYTE, SYNC_RESET);
		cfg_write(CFG_BURST_ID, BURST_RESET);
	endtask

	task automatic random_frame();
		int         len;
		int         ch;
		int         pick;
		logic [1:0] seq;
		bit         fin;
		src_idle = $urandom_range(0, 3) != 0;
		sink_idle = $urandom_range(0, 3) != 0;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			repeat ($urandom_range(1, 3)) send_byte(octet_t'($urandom));
		end else if (pick < 20) begin
			send_byte(frame_sync);
			send_byte($urandom_range(0, 1) ? 8'd0 : octet_t'($urandom_range(14, 255)));
		end
		len = ($urandom_range(0, 3) == 0) ? MAX_PAYLOAD : $urandom_range(1, MAX_PAYLOAD);
		if ($urandom_range(0, 1)) begin
			ch = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CHANNELS - 1) :
				$urandom_range(0, 3);
			seq = ($urandom_range(0, 3) != 0) ? next_seq[ch] : 2'($urandom_range(0, 3));
			fin = ($urandom_range(0, 5) == 0);
			next_seq[ch] = fin ? 2'd0 : ((seq == 2'd3) ? 2'd1 : seq + 2'd1);
			send_burst(ch, int'(seq), fin, len, $urandom_range(0, 9) == 0);
		end else begin
			for (int k = 0; k < MAX_PAYLOAD; k++) frame_pl[k] = octet_t'($urandom);
			send_frame(octet_t'($urandom), len, $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic test_random_traffic();
		int stop_at;
		for (int p = 0; p < 3; p++) begin
			if (p > 0) begin
				cfg_write(CFG_SYNC_BYTE, octet_t'($urandom));
				cfg_write(CFG_BURST_ID, octet_t'($urandom));
			end
			stop_at = items_sent + 5;
			while (items_sent < stop_at) random_frame();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.rx_byte <= '0;
		cfg.valid <= 1'b0;
		cfg.reg_index <= CFG_SYNC_BYTE;
		cfg.wdata <= '0;
		cycles = 0;
		errors = 0;
		items_sent = 0;
		hold_cycles = 0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		frame_sync = SYNC_RESET;
		frame_burst = BURST_RESET;
		for (int i = 0; i < CHANNELS; i++) next_seq[i] = 2'd0;
		reset_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_frames();
		test_length_errors();
		test_burst_sequences();
		test_backpressure();
		test_register_settings();
		test_random_traffic();

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("** rx_deframer_burst_tracker_top: PASSED **");
		end else begin
			$display("** rx_deframer_burst_tracker_top: FAILED **");
		end
		$finish;
	end

endmodule
